/* sv/assert_macros.svh */
// assertion macros shared by the rasterizer rtl
// no dependencies; taken in by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define ASSERT_ON(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rasterizer check failed");

// property checked on the first edge after reset is released
`define ASSERT_AFTER_RESET(label, clk, rst, prop) \
   label: assert property (@(posedge clk) $past(rst) && !rst |-> prop) \
      else $error("rasterizer reset check failed");

`endif

/* sv/mcr_pkg.sv */
// shared types and constants for the midpoint circle rasterizer
// no dependencies; imported by the front end, step queue, back end and top level
package mcr_pkg;

   localparam logic MODE_START   = 1'b0;
   localparam logic MODE_ADVANCE = 1'b1;

   // decision value carries this many bits above the radius width
   localparam int DEC_GUARD_BITS = 3;

   // entries in the step queue between front and back end (power of two)
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // symmetric point order within one step
   typedef enum logic [7:0] {
      OCT_XP_YP = 8'b0000_0001,
      OCT_XP_YN = 8'b0000_0010,
      OCT_XN_YP = 8'b0000_0100,
      OCT_XN_YN = 8'b0000_1000,
      OCT_YP_XP = 8'b0001_0000,
      OCT_YP_XN = 8'b0010_0000,
      OCT_YN_XP = 8'b0100_0000,
      OCT_YN_XN = 8'b1000_0000
   } octant_type;

endpackage

/* sv/mcr_step_queue.sv */
// short register queue of step records between front and back end
// depends on mcr_pkg for the queue depth and status struct
module mcr_step_queue
   import mcr_pkg::*;
#(
   parameter int WIDTH = 45
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output queue_status_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

/* sv/mcr_front.sv */
// front end: takes start and advance beats, runs the midpoint step, queues step records
// depends on mcr_pkg for mode codes, decision guard width and queue status
module mcr_front
   import mcr_pkg::*;
#(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 10
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic                                    in_mode,
   input  logic [RADIUS_BITS-1:0]                  in_radius,
   input  logic [COORD_BITS-1:0]                   in_center_x,
   input  logic [COORD_BITS-1:0]                   in_center_y,
   input  queue_status_type                        q_status,
   output logic                                    push,
   // record, low bit up: x, y, centre x, centre y, final
   output logic [2*RADIUS_BITS+2*COORD_BITS:0]     push_data
);

   localparam int DEC_W = RADIUS_BITS + DEC_GUARD_BITS;

   logic [RADIUS_BITS-1:0] x_ff, x_in;
   logic [RADIUS_BITS-1:0] y_ff, y_in;
   logic [DEC_W-1:0]       dec_ff, dec_in;
   logic [COORD_BITS-1:0]  cx_ff, cx_in;
   logic [COORD_BITS-1:0]  cy_ff, cy_in;
   logic                   active_ff, active_in;
   logic                   accept;
   logic [DEC_W-1:0]       x_dw, y_dw;

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;
   assign x_dw     = DEC_W'(x_ff);
   assign y_dw     = DEC_W'(y_ff);

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      dec_in = dec_ff;
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      if (in_mode == MODE_START) begin
         x_in   = '0;
         y_in   = in_radius;
         dec_in = DEC_W'(1) - DEC_W'(in_radius);
         cx_in  = in_center_x;
         cy_in  = in_center_y;
      end else if (dec_ff[DEC_W-1]) begin
         // midpoint inside the circle: keep y
         dec_in = dec_ff + (x_dw << 1) + DEC_W'(3);
         x_in   = x_ff + RADIUS_BITS'(1);
      end else begin
         dec_in = dec_ff + ((x_dw - y_dw) << 1) + DEC_W'(5);
         x_in   = x_ff + RADIUS_BITS'(1);
         y_in   = y_ff - RADIUS_BITS'(1);
      end
      active_in = (y_in > x_in);
   end

   // an advance with no circle in progress is taken and dropped
   assign push      = accept && ((in_mode == MODE_START) || active_ff);
   assign push_data = {!active_in, cy_in, cx_in, y_in, x_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (push) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         dec_ff <= dec_in;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
      end
   end

endmodule

/* sv/mcr_back.sv */
// back end: expands each queued step record into eight symmetric points
// depends on mcr_pkg for the octant sequence and queue status
module mcr_back
   import mcr_pkg::*;
#(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [2*RADIUS_BITS+2*COORD_BITS:0] head_data,
   input  queue_status_type                    q_status,
   output logic                                pop,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [COORD_BITS:0]                 out_point_x,
   output logic [COORD_BITS:0]                 out_point_y,
   output logic                                out_last
);

   localparam int POINT_BITS = COORD_BITS + 1;

   logic [RADIUS_BITS-1:0] rec_x, rec_y;
   logic [COORD_BITS-1:0]  rec_cx, rec_cy;
   logic                   rec_final;

   octant_type             oct_ff, oct_in;
   logic                   swap, neg_x, neg_y;
   logic                   load;
   logic                   valid_ff;
   logic [POINT_BITS-1:0]  px_ff, px_in;
   logic [POINT_BITS-1:0]  py_ff, py_in;
   logic                   last_ff;
   logic [POINT_BITS-1:0]  cx_ext, cy_ext, dx, dy;

   assign {rec_final, rec_cy, rec_cx, rec_y, rec_x} = head_data;

   always_comb begin
      unique case (oct_ff)
         OCT_XP_YP: begin swap = 1'b0; neg_x = 1'b0; neg_y = 1'b0; oct_in = OCT_XP_YN; end
         OCT_XP_YN: begin swap = 1'b0; neg_x = 1'b0; neg_y = 1'b1; oct_in = OCT_XN_YP; end
         OCT_XN_YP: begin swap = 1'b0; neg_x = 1'b1; neg_y = 1'b0; oct_in = OCT_XN_YN; end
         OCT_XN_YN: begin swap = 1'b0; neg_x = 1'b1; neg_y = 1'b1; oct_in = OCT_YP_XP; end
         OCT_YP_XP: begin swap = 1'b1; neg_x = 1'b0; neg_y = 1'b0; oct_in = OCT_YP_XN; end
         OCT_YP_XN: begin swap = 1'b1; neg_x = 1'b0; neg_y = 1'b1; oct_in = OCT_YN_XP; end
         OCT_YN_XP: begin swap = 1'b1; neg_x = 1'b1; neg_y = 1'b0; oct_in = OCT_YN_XN; end
         OCT_YN_XN: begin swap = 1'b1; neg_x = 1'b1; neg_y = 1'b1; oct_in = OCT_XP_YP; end
         default:   begin swap = 1'b0; neg_x = 1'b0; neg_y = 1'b0; oct_in = OCT_XP_YP; end
      endcase
   end

   // centre sign-extends, offsets zero-extend; sums wrap at the point width
   assign cx_ext = POINT_BITS'(signed'(rec_cx));
   assign cy_ext = POINT_BITS'(signed'(rec_cy));
   assign dx     = swap ? POINT_BITS'(rec_y) : POINT_BITS'(rec_x);
   assign dy     = swap ? POINT_BITS'(rec_x) : POINT_BITS'(rec_y);
   assign px_in  = neg_x ? (cx_ext - dx) : (cx_ext + dx);
   assign py_in  = neg_y ? (cy_ext - dy) : (cy_ext + dy);

   assign load = !q_status.empty && (!valid_ff || out_ready);
   assign pop  = load && (oct_ff == OCT_YN_XN);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         oct_ff   <= OCT_XP_YP;
      end else if (load) begin
         valid_ff <= 1'b1;
         oct_ff   <= oct_in;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         last_ff <= rec_final && (oct_ff == OCT_YN_XN);
      end
   end

   assign out_valid   = valid_ff;
   assign out_point_x = px_ff;
   assign out_point_y = py_ff;
   assign out_last    = last_ff;

endmodule

/* sv/midpoint_circle_rasterizer.sv */
// Midpoint circle rasterizer. A start beat (tuser 0) loads centre and radius and
// an advance beat (tuser 1) runs one midpoint step; each start, and each advance
// while a circle is in progress, yields eight symmetric points on the rsp channel,
// one per cycle while rsp_tready is held, the final point of the circle marked by
// tlast. An advance with no circle in progress is taken and yields nothing. The
// back end computes the points of one step record one at a time; a two-entry step
// queue lets the req side run up to two beats ahead of the rsp side, so a stalled
// rsp channel only backs up req once that queue fills.
// Depends on mcr_pkg, mcr_front, mcr_step_queue, mcr_back and assert_macros.svh.
`include "assert_macros.svh"

module midpoint_circle_rasterizer
   import mcr_pkg::*;
#(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // low bit up: radius, center_x, center_y, zero pad to bytes
   input  logic [((RADIUS_BITS+2*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // mode
   input  logic                req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // low bit up: point_x, point_y, zero pad to bytes
   output logic [((2*COORD_BITS+2+7)/8)*8-1:0] rsp_tdata,
   output logic                rsp_tlast
);

   localparam int OUT_W = ((2 * COORD_BITS + 2 + 7) / 8) * 8;
   localparam int REC_W = 2 * RADIUS_BITS + 2 * COORD_BITS + 1;

   logic [REC_W-1:0]      push_data, head_data;
   logic                  push, pop;
   queue_status_type      q_status;
   logic [COORD_BITS:0]   point_x, point_y;

   mcr_front #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_mode     (req_tuser),
      .in_radius   (req_tdata[RADIUS_BITS-1:0]),
      .in_center_x (req_tdata[RADIUS_BITS+COORD_BITS-1:RADIUS_BITS]),
      .in_center_y (req_tdata[RADIUS_BITS+2*COORD_BITS-1:RADIUS_BITS+COORD_BITS]),
      .q_status    (q_status),
      .push        (push),
      .push_data   (push_data)
   );

   mcr_step_queue #(
      .WIDTH (REC_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (q_status)
   );

   mcr_back #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_data   (head_data),
      .q_status    (q_status),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_point_x (point_x),
      .out_point_y (point_y),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = OUT_W'({point_y, point_x});

   `ASSERT_ON(a_no_push_when_full, clock, reset, push |-> !q_status.full)
   `ASSERT_ON(a_no_pop_when_empty, clock, reset, pop |-> !q_status.empty)
   `ASSERT_ON(a_queue_status_sane, clock, reset, !(q_status.full && q_status.empty))
   `ASSERT_AFTER_RESET(a_rsp_idle_after_reset, clock, reset, !rsp_tvalid)

endmodule
